// ----- hdl/property_logical_line_reader_unit_assert.svh -----
// Assertion helpers for the logical line reader.
// All three expect clk and arst_n in scope.
`ifndef PROPERTY_LOGICAL_LINE_READER_UNIT_ASSERT_SVH
`define PROPERTY_LOGICAL_LINE_READER_UNIT_ASSERT_SVH

// cond must hold at every edge outside reset
`define PLR_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// ante implies cons in the same cycle
`define PLR_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// ante implies cons in the next cycle
`define PLR_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/plr_pkg.sv -----
package plr_pkg;

	localparam logic [7:0] CharBslash = 8'h5C;
	localparam logic [7:0] CharCr     = 8'h0D;
	localparam logic [7:0] CharLf     = 8'h0A;
	localparam logic [7:0] CharTab    = 8'h09;
	localparam logic [7:0] CharFf     = 8'h0C;
	localparam logic [7:0] CharSpace  = 8'h20;

	localparam int MaxCommentChars = 4;

	localparam logic [31:0] CommentCharsReset = 32'h0000_2123;
	localparam logic [2:0]  CommentCountReset = 3'd2;

	typedef enum logic [1:0] {
		CFG_COMMENT_CHARS   = 2'd0,
		CFG_COMMENT_COUNT   = 2'd1,
		CFG_INLINE_COMMENTS = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		KIND_CHAR = 2'd0,
		KIND_EOL  = 2'd1,
		KIND_EOI  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [31:0] comment_chars;
		logic [2:0]  comment_count;
		logic        inline_comments;
	} cfg_t;

	typedef struct packed {
		logic       skip_blanks;
		logic       in_comment_line;
		logic       inline_cut;
		logic       at_line_start;
		logic       after_join;
		logic       odd_backslash_held;
		logic       drop_next_lf;
		logic [1:0] line_length_sat;
	} line_state_t;

	localparam line_state_t LineReset = '{
		skip_blanks: 1'b1, in_comment_line: 1'b0, inline_cut: 1'b0,
		at_line_start: 1'b1, after_join: 1'b0, odd_backslash_held: 1'b0,
		drop_next_lf: 1'b0, line_length_sat: 2'd0
	};

	typedef struct packed {
		logic [7:0] out_byte;
		kind_t      kind;
		logic       last;
	} result_t;

	// up to two results from one input beat
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} push_t;

	function automatic logic is_indicator(input cfg_t cfg, input logic [7:0] c);
		logic [2:0] n;
		logic       hit;
		n = (cfg.comment_count > 3'(MaxCommentChars)) ? 3'(MaxCommentChars)
			: cfg.comment_count;
		hit = 1'b0;
		for (int i = 0; i < MaxCommentChars; i++) begin
			if (3'(i) < n && cfg.comment_chars[8*i +: 8] == c)
				hit = 1'b1;
		end
		return hit;
	endfunction

endpackage

// ----- hdl/plr_core.sv -----
module plr_core (
	input  logic                clk,
	input  logic                arst_n,
	input  plr_pkg::cfg_t       cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          char_byte,
	input  logic                end_of_input,
	input  logic                room,
	output plr_pkg::push_t      push
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 eoi_s1;
	logic                 fire;
	plr_pkg::line_state_t st_q;
	plr_pkg::line_state_t st_d;
	plr_pkg::push_t       res;
	logic                 done;
	logic                 blank;
	logic                 brk;
	logic                 ind;

	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= char_byte;
			eoi_s1  <= end_of_input;
		end
	end

	assign blank = byte_s1 == plr_pkg::CharSpace || byte_s1 == plr_pkg::CharTab
		|| byte_s1 == plr_pkg::CharFf;
	assign brk   = byte_s1 == plr_pkg::CharCr || byte_s1 == plr_pkg::CharLf;
	assign ind   = plr_pkg::is_indicator(cfg, byte_s1);

	always_comb begin
		st_d     = st_q;
		res      = '0;
		res.r0.kind = plr_pkg::KIND_CHAR;
		res.r1.kind = plr_pkg::KIND_CHAR;
		done     = 1'b0;
		if (eoi_s1) begin
			if (st_q.line_length_sat == 2'd0 || st_q.in_comment_line) begin
				res.count   = 2'd1;
				res.r0.kind = plr_pkg::KIND_EOI;
			end else if (st_q.odd_backslash_held) begin
				res.count       = 2'd2;
				res.r0.out_byte = plr_pkg::CharBslash;
				res.r1.kind     = plr_pkg::KIND_EOL;
			end else begin
				res.count   = 2'd1;
				res.r0.kind = plr_pkg::KIND_EOL;
			end
			st_d = plr_pkg::LineReset;
		end else begin
			if (st_q.drop_next_lf) begin
				st_d.drop_next_lf = 1'b0;
				if (byte_s1 == plr_pkg::CharLf)
					done = 1'b1;
			end
			if (!done && st_d.skip_blanks) begin
				if (blank) begin
					done = 1'b1;
				end else if (!st_d.after_join && brk) begin
					done = 1'b1;
				end else begin
					st_d.skip_blanks = 1'b0;
					st_d.after_join  = 1'b0;
				end
			end
			if (!done && st_d.at_line_start) begin
				st_d.at_line_start = 1'b0;
				if (ind) begin
					st_d.in_comment_line = 1'b1;
					done = 1'b1;
				end
			end
			if (!done && cfg.inline_comments && !st_d.in_comment_line && !st_d.inline_cut
				&& !st_d.odd_backslash_held && ind) begin
				st_d.inline_cut = 1'b1;
				done = 1'b1;
			end
			if (!done && !brk) begin
				done = 1'b1;
				if (!st_d.in_comment_line && !st_d.inline_cut) begin
					if (st_d.line_length_sat != 2'd3)
						st_d.line_length_sat = st_d.line_length_sat + 2'd1;
					if (byte_s1 == plr_pkg::CharBslash) begin
						if (st_d.odd_backslash_held) begin
							res.count       = 2'd2;
							res.r0.out_byte = plr_pkg::CharBslash;
							res.r1.out_byte = plr_pkg::CharBslash;
						end
						st_d.odd_backslash_held = !st_d.odd_backslash_held;
					end else if (st_d.odd_backslash_held) begin
						res.count       = 2'd2;
						res.r0.out_byte = plr_pkg::CharBslash;
						res.r1.out_byte = byte_s1;
						st_d.odd_backslash_held = 1'b0;
					end else begin
						res.count       = 2'd1;
						res.r0.out_byte = byte_s1;
					end
				end
			end
			if (!done) begin
				if (st_d.in_comment_line || st_d.line_length_sat == 2'd0) begin
					st_d = plr_pkg::LineReset;
				end else if (st_d.odd_backslash_held) begin
					// line join: drop the backslash, CR LF is one break
					st_d.line_length_sat    = st_d.line_length_sat - 2'd1;
					st_d.skip_blanks        = 1'b1;
					st_d.after_join         = 1'b1;
					st_d.odd_backslash_held = 1'b0;
					st_d.drop_next_lf       = byte_s1 == plr_pkg::CharCr;
				end else begin
					res.count   = 2'd1;
					res.r0.kind = plr_pkg::KIND_EOL;
					st_d = plr_pkg::LineReset;
				end
			end
		end
		if (res.count == 2'd1)
			res.r0.last = 1'b1;
		if (res.count == 2'd2)
			res.r1.last = 1'b1;
		if (!fire)
			res.count = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= plr_pkg::LineReset;
		end else if (fire) begin
			st_q <= st_d;
		end
	end

	assign push = res;

endmodule

// ----- hdl/plr_fifo.sv -----
module plr_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  plr_pkg::push_t     push,
	output logic               room,
	output logic [2:0]         level,
	output logic               out_valid,
	input  logic               out_ready,
	output plr_pkg::result_t   head
);

	localparam int Depth = 4;

	plr_pkg::result_t mem_q [Depth];
	logic [1:0]       wr_q;
	logic [1:0]       rd_q;
	logic [2:0]       count_q;
	logic             pop;

	assign out_valid = count_q != 3'd0;
	assign pop       = out_valid && out_ready;
	assign room      = count_q <= 3'(Depth - 2);
	assign head      = mem_q[rd_q];
	assign level     = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + push.count;
			rd_q    <= rd_q + 2'(pop);
			count_q <= count_q + 3'(push.count) - 3'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem_q[wr_q] <= push.r0;
		if (push.count == 2'd2)
			mem_q[wr_q + 2'd1] <= push.r1;
	end

endmodule

// ----- hdl/property_logical_line_reader_unit.sv -----
// Logical line reader for property text.
// Input channel (in_valid/in_ready): one beat per byte in char_byte; a beat with
// end_of_input set closes the pending line and char_byte is ignored.
// Output channel (out_valid/out_ready): one beat per result. kind 0 carries a line
// character in out_byte, kind 1 ends a logical line, kind 2 reports end of input
// with no line pending. last marks the final result caused by one input beat.
// A byte can yield zero, one or two results (a held backslash plus the byte).
// Config: cfg_we writes cfg_data into register cfg_index (0 comment bytes,
// 1 comment count, 2 inline comment enable); write only while the block is idle.
// A beat's first result is offered after the input register and the result queue.
// Throughput: one input beat per cycle while the queue has room; the queue drains
// one beat per cycle, so a long run of two-result bytes is paced by the output port.
// A four-entry result queue sits between the line logic and the output, and the
// input register keeps taking beats while the queue has room for two results.
// On out_ready low, the queue fills and then in_ready falls.
// Reset clears all line state, empties the queue and restores the default config.
module property_logical_line_reader_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_byte,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic [1:0]  kind,
	output logic        last,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	plr_pkg::cfg_t    cfg_q;
	plr_pkg::push_t   push;
	plr_pkg::result_t head;
	logic             room;
	logic [2:0]       level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.comment_chars   <= plr_pkg::CommentCharsReset;
			cfg_q.comment_count   <= plr_pkg::CommentCountReset;
			cfg_q.inline_comments <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				plr_pkg::CFG_COMMENT_CHARS:   cfg_q.comment_chars   <= cfg_data;
				plr_pkg::CFG_COMMENT_COUNT:   cfg_q.comment_count   <= cfg_data[2:0];
				plr_pkg::CFG_INLINE_COMMENTS: cfg_q.inline_comments <= cfg_data[0];
				default: ;
			endcase
		end
	end

	plr_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_byte    (char_byte),
		.end_of_input (end_of_input),
		.room         (room),
		.push         (push)
	);

	plr_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.level     (level),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head)
	);

	assign out_byte = head.out_byte;
	assign kind     = head.kind;
	assign last     = head.last;

`include "property_logical_line_reader_unit_assert.svh"

	`PLR_ASSERT_ALWAYS(a_level_bound, level <= 3'd4, "result queue overflow")
	`PLR_ASSERT_IMPL(a_marker_byte, out_valid && kind != plr_pkg::KIND_CHAR,
		out_byte == 8'd0 && last, "end marker with data or not last")
	`PLR_ASSERT_IMPL(a_push_room, push.count != 2'd0, level <= 3'd2,
		"results pushed without room")
	`PLR_ASSERT_NEXT(a_valid_empty, level == 3'd0 && push.count == 2'd0, !out_valid,
		"output valid with empty queue")

endmodule
